### rtl/core/wrs_pkg.sv
// wrs_pkg: shared types and codes for the weighted random select block
// no dependencies
package wrs_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_DRAW    = 2'd1;
  localparam logic [1:0] OP_DRAWRM  = 2'd2;
  localparam logic [1:0] OP_RESTORE = 2'd3;

  localparam logic [1:0] ST_PICKED = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;
  localparam logic [1:0] ST_ACK    = 2'd3;

  localparam logic CFG_ITEM_COUNT = 1'b0;
  localparam logic CFG_PICK_LIMIT = 1'b1;

  // command word handed from front to back
  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  slot;
    logic [31:0] item_value;
    logic [15:0] item_weight;
    logic [30:0] random_value;
  } wrs_cmd_t;

  typedef struct packed {
    logic [31:0] picked_item;
    logic [5:0]  picked_slot;
    logic [1:0]  status;
  } wrs_res_t;

endpackage

### rtl/core/wrs_ram.sv
// wrs_ram: generic single port write, one read port, registered read
// no dependencies
module wrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/wrs_fifo.sv
// wrs_fifo: two entry command queue between front and back
// depends on wrs_pkg
module wrs_fifo
  import wrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  wrs_cmd_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output wrs_cmd_t out_data
);

  wrs_cmd_t   buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        buf_r[wp_r] <= in_data;
        wp_r        <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !out_valid) else $error("valid on empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ready) else $error("ready on full queue");

endmodule

### rtl/core/wrs_engine.sv
// wrs_engine: back end, table memories, sum pass, modulo, walk pass
// depends on wrs_pkg, wrs_ram
module wrs_engine
  import wrs_pkg::*;
#(
  parameter int MAX_ITEMS   = 64,
  parameter int ITEM_BITS   = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic [6:0] item_count,
  input  logic [6:0] pick_limit,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  wrs_cmd_t cmd,
  output logic     res_valid,
  input  logic     res_ready,
  output wrs_res_t res
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int TW = WEIGHT_BITS + AW;

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_DIV, S_WALK, S_READ, S_OUT
  } state_t;

  state_t          state_r;
  logic [MAX_ITEMS-1:0] live_r;
  logic [6:0]      picked_r;
  logic [CW-1:0]   n_r;
  logic [CW:0]     idx_r;
  logic [TW-1:0]   total_r;
  logic            any_r;
  logic [30:0]     rem_r;
  logic [5:0]      div_cnt_r;
  logic [TW-1:0]   r_r;
  logic            rm_r;
  logic [AW-1:0]   pick_r;
  logic            out_v_r;
  wrs_res_t        res_r;
  logic [30:0]     quo_r;

  logic [ITEM_BITS-1:0]   item_rd;
  logic [WEIGHT_BITS-1:0] wt_rd;
  logic [AW-1:0]          raddr;
  logic                   we;
  logic [CW-1:0]          n_in;
  logic [AW-1:0]          first_idx;
  logic                   first_found;
  logic [TW:0]            rem_try;
  logic [31:0]            item_ext;

  assign we = cmd_valid && cmd_ready && cmd.opcode == OP_LOAD
              && {1'b0, cmd.slot} < 7'(MAX_ITEMS);

  wrs_ram #(.WIDTH(ITEM_BITS), .DEPTH(MAX_ITEMS)) u_items (
    .clk, .we, .waddr(AW'(cmd.slot)), .wdata(cmd.item_value[ITEM_BITS-1:0]),
    .raddr, .rdata(item_rd)
  );
  wrs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ITEMS)) u_weights (
    .clk, .we, .waddr(AW'(cmd.slot)), .wdata(cmd.item_weight[WEIGHT_BITS-1:0]),
    .raddr, .rdata(wt_rd)
  );

  assign n_in = (item_count > 7'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : CW'(item_count);
  assign raddr = (state_r == S_READ) ? pick_r : idx_r[AW-1:0];
  assign cmd_ready = (state_r == S_IDLE) && !out_v_r;
  assign res_valid = out_v_r;
  assign res = res_r;
  assign rem_try = {rem_r[TW-1:0], quo_r[30]} - {1'b0, total_r};

  // lowest live slot in use
  always_comb begin
    first_idx   = '0;
    first_found = 1'b0;
    for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
      if (live_r[i] && i < int'(n_in)) begin
        first_idx   = AW'(i);
        first_found = 1'b1;
      end
    end
  end

  generate
    if (ITEM_BITS >= 32) begin : g_iw
      assign item_ext = item_rd[31:0];
    end else begin : g_in
      assign item_ext = {{(32-ITEM_BITS){1'b0}}, item_rd};
    end
  endgenerate

  // cur_r is idx_r from the cycle before, lined up with the registered read
  logic [AW-1:0] cur_r;
  logic          cur_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      live_r   <= '1;
      picked_r <= '0;
      out_v_r  <= 1'b0;
      cur_v_r  <= 1'b0;
    end else begin
      if (out_v_r && res_ready) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            rm_r    <= (cmd.opcode == OP_DRAWRM);
            n_r     <= n_in;
            idx_r   <= '0;
            total_r <= '0;
            any_r   <= 1'b0;
            cur_v_r <= 1'b0;
            quo_r   <= cmd.random_value;
            res_r.picked_item <= '0;
            res_r.picked_slot <= '0;
            res_r.status      <= (cmd.opcode inside {OP_LOAD, OP_RESTORE}) ? ST_ACK
                                                                           : ST_DONE;
            if (cmd.opcode == OP_LOAD) begin
              out_v_r      <= 1'b1;
            end else if (cmd.opcode == OP_RESTORE) begin
              live_r       <= '1;
              picked_r     <= '0;
              out_v_r      <= 1'b1;
            end else if (cmd.opcode == OP_DRAWRM && {{(7-CW){1'b0}}, n_in} <= pick_limit) begin
              if (first_found) begin
                pick_r  <= first_idx;
                state_r <= S_READ;
              end else begin
                out_v_r <= 1'b1;
              end
            end else if (cmd.opcode == OP_DRAWRM && picked_r >= pick_limit) begin
              out_v_r <= 1'b1;
            end else begin
              state_r <= S_SUM;
            end
          end
        end
        S_SUM: begin
          cur_r   <= idx_r[AW-1:0];
          cur_v_r <= (idx_r < {1'b0, n_r});
          if (idx_r < {1'b0, n_r}) idx_r <= idx_r + 1'b1;
          if (cur_v_r && live_r[cur_r]) begin
            total_r <= total_r + TW'(wt_rd);
            any_r   <= 1'b1;
          end
          if (!(idx_r < {1'b0, n_r}) && !cur_v_r) begin
            if (!any_r) begin
              out_v_r <= 1'b1;
              state_r <= S_IDLE;
            end else if (total_r == '0) begin
              res_r.status <= ST_ZERO;
              out_v_r      <= 1'b1;
              state_r      <= S_IDLE;
            end else begin
              rem_r     <= '0;
              div_cnt_r <= '0;
              state_r   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          quo_r <= {quo_r[29:0], 1'b0};
          if (!rem_try[TW])
            rem_r <= 31'(rem_try[TW-1:0]);
          else
            rem_r <= {rem_r[29:0], quo_r[30]};
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == 6'd30) begin
            idx_r   <= '0;
            cur_v_r <= 1'b0;
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (!cur_v_r) begin
            r_r     <= rem_r[TW-1:0];
            cur_r   <= '0;
            cur_v_r <= 1'b1;
            idx_r   <= idx_r + 1'b1;
          end else begin
            cur_r <= idx_r[AW-1:0];
            idx_r <= idx_r + 1'b1;
            if (live_r[cur_r] && CW'(cur_r) < n_r) begin
              if (r_r < TW'(wt_rd)) begin
                pick_r  <= cur_r;
                state_r <= S_READ;
              end else begin
                r_r <= r_r - TW'(wt_rd);
              end
            end
            if (CW'(cur_r) + 1'b1 >= n_r && !(live_r[cur_r]
                && r_r < TW'(wt_rd))) begin
              out_v_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end
        end
        S_READ: state_r <= S_OUT;
        S_OUT: begin
          res_r.picked_item <= item_ext;
          res_r.picked_slot <= 6'(pick_r);
          res_r.status      <= ST_PICKED;
          out_v_r           <= 1'b1;
          if (rm_r) begin
            live_r[pick_r] <= 1'b0;
            if (picked_r != 7'd127) picked_r <= picked_r + 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !cmd_ready) else $error("command taken while busy");
  a_pick_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> live_r[pick_r]) else $error("picked slot not live");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !res_ready |=> out_v_r) else $error("result dropped");

endmodule

### rtl/core/weighted_random_select_top.sv
// weighted_random_select_top: front end, command queue and back end
// depends on wrs_pkg, wrs_fifo, wrs_engine
//
// channel | direction | words
// in_     | slave     | command word
// out_    | master    | one result word per command
// cfg_    | write     | item_count (0), pick_limit (1)
//
// load and restore: answered from the idle state; draw: take, sum pass, serial divide,
// walk pass, table read, result, its time set by the single table read port and the divider
// draw-remove: lowest live slot if item_count <= pick_limit, none after pick_limit picks
// reset marks every slot live, clears pick count, state and config; table contents stay undefined
// the queue takes two commands while the back end or the output stalls
module weighted_random_select_top
  import wrs_pkg::*;
#(
  parameter int MAX_ITEMS   = 64,
  parameter int ITEM_BITS   = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,  // opcode, slot, item_value, item_weight, random_value
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata, // picked_item, picked_slot, status
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [6:0]   cfg_wdata
);

  logic [6:0] item_count_r, pick_limit_r;
  wrs_cmd_t   in_cmd, q_cmd;
  wrs_res_t   res;
  logic       q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= '0;
      pick_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ITEM_COUNT: item_count_r <= cfg_wdata;
        CFG_PICK_LIMIT: pick_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_cmd.opcode       = in_tdata[1:0];
  assign in_cmd.slot         = in_tdata[7:2];
  assign in_cmd.item_value   = in_tdata[39:8];
  assign in_cmd.item_weight  = in_tdata[55:40];
  assign in_cmd.random_value = in_tdata[86:56];

  wrs_fifo u_fifo (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_cmd)
  );

  wrs_engine #(.MAX_ITEMS(MAX_ITEMS), .ITEM_BITS(ITEM_BITS),
               .WEIGHT_BITS(WEIGHT_BITS)) u_engine (
    .clk, .rst_n, .item_count(item_count_r), .pick_limit(pick_limit_r),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {res.status, res.picked_slot, res.picked_item};

endmodule
